// ----- rtl/pssf_pkg.sv -----
// ----------------------------------------------------------------------------
// pssf_pkg
// Shared types and constants for the per-source sequence filter.
// ----------------------------------------------------------------------------
package pssf_pkg;

  localparam int unsigned MaxSenders = 32;
  localparam int unsigned IdxW       = (MaxSenders > 1) ? $clog2(MaxSenders) : 1;
  localparam int unsigned CntW       = $clog2(MaxSenders + 1);
  localparam int unsigned AddrW      = 32;
  localparam int unsigned SeqW       = 16;
  localparam int unsigned SeqResetGap = 16;

  typedef enum logic [1:0] {
    StNewer     = 2'd0,
    StHardReset = 2'd1,
    StStale     = 2'd2,
    StFull      = 2'd3
  } status_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [SeqW-1:0]  seq;
  } entry_t;

  typedef struct packed {
    logic            re;
    logic [IdxW-1:0] raddr;
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
  } ram_req_t;

endpackage

// ----- rtl/pssf_ram.sv -----
// ----------------------------------------------------------------------------
// pssf_ram
// Sender table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pssf_ram
  import pssf_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [MaxSenders];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pssf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pssf_ctrl
// Table scan, sequence judgement, write-back and result register.
// ----------------------------------------------------------------------------
module pssf_ctrl
  import pssf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [AddrW-1:0] source_address_i,
  input  logic [SeqW-1:0]  sequence_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             accepted_o,
  output logic [1:0]       status_o,
  output ram_req_t         ram_req_o,
  input  entry_t           ram_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_JUDGE
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] src_q, src_d;
  logic [SeqW-1:0]  seq_q, seq_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  cmp_idx_q, cmp_idx_d;
  logic             cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic [SeqW-1:0]  last_q, last_d;
  logic             new_q, new_d;
  logic             full_q, full_d;
  logic             out_valid_q, out_valid_d;
  logic             acc_q, acc_d;
  status_e          status_q, status_d;

  logic             out_load;
  logic             table_full;
  logic             is_newer;
  logic             is_hard_reset;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign table_full = (count_q == CntW'(MaxSenders));
  assign is_newer   = (seq_q > last_q);
  // 17-bit compare: no wrap on seq + gap
  assign is_hard_reset = ({1'b0, seq_q} + (SeqW+1)'(SeqResetGap)) < {1'b0, last_q};

  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    seq_d       = seq_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_valid_d = 1'b0;
    slot_d      = slot_q;
    last_d      = last_q;
    new_d       = new_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && out_stall_i;
    acc_d       = acc_q;
    status_d    = status_q;
    ram_req_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          src_d    = source_address_i;
          seq_d    = sequence_req_i;
          rd_idx_d = '0;
          if (count_q == '0) begin
            new_d   = 1'b1;
            full_d  = 1'b0;
            slot_d  = '0;
            last_d  = '0;
            state_d = S_JUDGE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // one read issued per cycle, compared in the cycle after the read
        if (rd_idx_q < count_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = rd_idx_q[IdxW-1:0];
          rd_idx_d        = rd_idx_q + 1'b1;
          cmp_valid_d     = 1'b1;
          cmp_idx_d       = rd_idx_q;
        end
        if (cmp_valid_q) begin
          if (ram_rdata_i.addr == src_q) begin
            slot_d      = cmp_idx_q[IdxW-1:0];
            last_d      = ram_rdata_i.seq;
            new_d       = 1'b0;
            full_d      = 1'b0;
            cmp_valid_d = 1'b0;
            state_d     = S_JUDGE;
          end else if (CntW'(cmp_idx_q + 1'b1) == count_q) begin
            // miss: add at the end, or report full
            slot_d      = count_q[IdxW-1:0];
            last_d      = '0;
            new_d       = !table_full;
            full_d      = table_full;
            cmp_valid_d = 1'b0;
            state_d     = S_JUDGE;
          end
        end
      end
      S_JUDGE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (full_q) begin
            acc_d    = 1'b0;
            status_d = StFull;
          end else if (is_newer) begin
            acc_d    = 1'b1;
            status_d = StNewer;
          end else if (is_hard_reset) begin
            acc_d    = 1'b1;
            status_d = StHardReset;
          end else begin
            acc_d    = 1'b0;
            status_d = StStale;
          end
          // a new entry is written even when stale; then seq is zero anyway
          if (!full_q && (new_q || is_newer || is_hard_reset)) begin
            ram_req_o.we         = 1'b1;
            ram_req_o.waddr      = slot_q;
            ram_req_o.wdata.addr = src_q;
            ram_req_o.wdata.seq  = seq_q;
          end
          if (new_q) begin
            count_d = count_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      src_q       <= '0;
      seq_q       <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_idx_q   <= '0;
      cmp_valid_q <= 1'b0;
      slot_q      <= '0;
      last_q      <= '0;
      new_q       <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      status_q    <= StNewer;
    end else begin
      state_q     <= state_d;
      src_q       <= src_d;
      seq_q       <= seq_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_valid_q <= cmp_valid_d;
      slot_q      <= slot_d;
      last_q      <= last_d;
      new_q       <= new_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      status_q    <= status_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accepted_o  = acc_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/per_source_sequence_filter_core.sv -----
// ----------------------------------------------------------------------------
// per_source_sequence_filter_core
// Replay filter: per-sender last sequence number kept in a sender table.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o | source_address_i, sequence_req_i
//  out     | out_valid_o / out_stall_i | accepted_o, status_o
//
// A packet is scanned against the N senders in the table (skipped when empty):
// one table read per cycle through the single read port, a compare on the
// registered read data, stopping at a match; then one judge and write-back step.
// Reset empties the table at once (fill count); no clearing pass.
// The result register frees the scan; a stalled result holds only the
// write-back step.
// ----------------------------------------------------------------------------
module per_source_sequence_filter_core
  import pssf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [AddrW-1:0] source_address_i,
  input  logic [SeqW-1:0]  sequence_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             accepted_o,
  output logic [1:0]       status_o
);

  ram_req_t ram_req;
  entry_t   ram_rdata;

  pssf_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .source_address_i (source_address_i),
    .sequence_req_i   (sequence_req_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .status_o         (status_o),
    .ram_req_o        (ram_req),
    .ram_rdata_i      (ram_rdata)
  );

  pssf_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- dv/pssf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pssf_checker
// Watches both channels of the sequence filter, keeps its own copy of the
// sender table to predict each verdict, and compares every output transfer
// against the oldest prediction.
// ----------------------------------------------------------------------------
module pssf_checker
  import pssf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [AddrW-1:0]      source_address_i,
  input  logic [SeqW-1:0]       sequence_req_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  accepted_i,
  input  logic [1:0]            status_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_count_o,
  output logic [3:0][31:0]      tally_o
);

  typedef struct packed {
    logic    accepted;
    status_e status;
  } verdict_t;

  logic [AddrW-1:0] known_addr [MaxSenders];
  logic [SeqW-1:0]  known_seq  [MaxSenders];
  int unsigned      known_count;
  verdict_t         expected_verdicts [$];

  // Table lookup, insert of unknown senders and the newer / hard-reset test.
  function automatic verdict_t judge_packet(logic [AddrW-1:0] src, logic [SeqW-1:0] seq);
    verdict_t v;
    int       slot;
    slot = -1;
    for (int i = 0; i < int'(known_count); i++) begin
      if (slot < 0 && known_addr[i] == src) slot = i;
    end
    if (slot < 0 && known_count < MaxSenders) begin
      slot = int'(known_count);
      known_addr[slot] = src;
      known_seq[slot]  = '0;
      known_count++;
    end
    if (slot < 0) begin
      v.accepted = 1'b0;
      v.status   = StFull;
    end else if (seq > known_seq[slot]) begin
      known_seq[slot] = seq;
      v.accepted = 1'b1;
      v.status   = StNewer;
    end else if (({1'b0, seq} + 17'(SeqResetGap)) < {1'b0, known_seq[slot]}) begin
      known_seq[slot] = seq;
      v.accepted = 1'b1;
      v.status   = StHardReset;
    end else begin
      v.accepted = 1'b0;
      v.status   = StStale;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t want;
    if (!rst_ni) begin
      known_count = 0;
      expected_verdicts.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
      tally_o          <= '0;
    end else begin
      // Output side first: a result transfer always belongs to an older packet.
      if (out_valid_i && !out_stall_i) begin
        tally_o[status_i] <= tally_o[status_i] + 1;
        if (expected_verdicts.size() == 0) begin
          $error("result transfer with no packet outstanding (accepted=%0d status=%0d)",
                 accepted_i, status_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (want.accepted !== accepted_i || want.status !== status_i)
            mismatch_count_o <= mismatch_count_o + 1;
          if (want.accepted !== accepted_i)
            $error("accepted: expected %0d, actual %0d", want.accepted, accepted_i);
          if (want.status !== status_i)
            $error("status: expected %0d, actual %0d", want.status, status_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_verdicts.push_back(judge_packet(source_address_i, sequence_req_i));
      pending_count_o <= expected_verdicts.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the per-source sequence filter: directed edge
// packets, then random traffic from a sender pool that fills the table, with
// random idling and output stalls.
// ----------------------------------------------------------------------------
module tb_top
  import pssf_pkg::*;
();

  localparam int unsigned NumRandom   = 1336;
  localparam int unsigned PoolSize    = 48;
  localparam int unsigned HotSenders  = 30;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 40;

  logic             clk_i;
  logic             rst_ni           = 1'b0;
  logic             in_valid_i       = 1'b0;
  logic [AddrW-1:0] source_address_i = '0;
  logic [SeqW-1:0]  sequence_req_i   = '0;
  logic             out_stall_i      = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic             accepted_o;
  logic [1:0]       status_o;

  int unsigned      mismatch_count;
  int unsigned      pending_count;
  logic [3:0][31:0] tally;

  logic             no_idle = 1'b0;
  int unsigned      quiet_cycles = 0;

  logic [AddrW-1:0] pool_addr [PoolSize];
  logic [SeqW-1:0]  pool_last [PoolSize];
  int unsigned      pool_active = 0;

  per_source_sequence_filter_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .source_address_i (source_address_i),
    .sequence_req_i   (sequence_req_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .status_o         (status_o)
  );

  pssf_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .source_address_i (source_address_i),
    .sequence_req_i   (sequence_req_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_i       (accepted_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .tally_o          (tally)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 33);
  end

  // Watchdog: quiet_cycles counts clocks without a transfer on either channel; reaching IdleLimit ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called right after a posedge (or at start); valid is only written once per
  // falling edge so back-to-back transfers keep valid high.
  task automatic send_packet(logic [AddrW-1:0] src, logic [SeqW-1:0] seq);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    source_address_i <= src;
    sequence_req_i   <= seq;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sequence shaped around the last number sent to this sender so the
  // newer / duplicate / near-miss / hard-reset boundaries all get hit.
  function automatic logic [SeqW-1:0] pick_seq(logic [SeqW-1:0] last);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      return last + SeqW'($urandom_range(1, 5));
    else if (roll < 55) return last;
    else if (roll < 70) return last - SeqW'($urandom_range(1, 20));
    else if (roll < 80) return last - SeqW'($urandom_range(21, 4000));
    else if (roll < 90) return SeqW'($urandom);
    else begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return SeqW'(SeqResetGap);
        default: return SeqW'(SeqResetGap + 1);
      endcase
    end
  endfunction

  initial begin : stimulus
    int unsigned      idx;
    int unsigned      hot;
    logic [SeqW-1:0]  seq;

    for (int i = 0; i < PoolSize; i++) begin
      pool_addr[i] = $urandom;
      pool_last[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // First packet of a new sender with sequence 0 is stale.
    send_packet(32'h0000_0000, 16'h0000);
    send_packet(32'h0000_0000, 16'hFFFF);
    send_packet(32'h0000_0000, 16'hFFFF);
    // Exactly 16 below is still stale; 17 below is a hard reset.
    send_packet(32'h0000_0000, 16'hFFEF);
    send_packet(32'h0000_0000, 16'hFFEE);
    send_packet(32'hFFFF_FFFF, 16'h0001);
    send_packet(32'hFFFF_FFFF, 16'h0000);
    send_packet(32'hFFFF_FFFF, 16'h0011);
    send_packet(32'hFFFF_FFFF, 16'h0001);
    send_packet(32'hFFFF_FFFF, 16'h0000);
    send_packet(32'hFFFF_FFFF, 16'h0000);
    send_packet(32'h5555_AAAA, 16'h8000);
    send_packet(32'h5555_AAAA, 16'h7FFF);
    send_packet(32'hAAAA_5555, 16'h0010);

    for (int n = 0; n < NumRandom; n++) begin
      no_idle = (n >= 600 && n < 800);
      if ($urandom_range(0, 99) < 3) begin
        // Stray sender: added while room is left, table full afterwards.
        send_packet($urandom, SeqW'($urandom));
      end else begin
        if (pool_active == 0 || (pool_active < PoolSize && $urandom_range(0, 99) < 10)) begin
          idx = pool_active;
          pool_active++;
        end else begin
          hot = (pool_active < HotSenders) ? pool_active : HotSenders;
          if ($urandom_range(0, 99) < 90) idx = $urandom_range(0, hot - 1);
          else                            idx = $urandom_range(0, pool_active - 1);
        end
        seq = pick_seq(pool_last[idx]);
        pool_last[idx] = seq;
        send_packet(pool_addr[idx], seq);
      end
    end
    no_idle = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Packets filtered: %0d newer, %0d hard reset, %0d stale, %0d table full",
             tally[StNewer], tally[StHardReset], tally[StStale], tally[StFull]);
    $display("Sender pool of %0d addresses plus stray sources, with random idle and stall",
             pool_active);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- per_source_sequence_filter_core.f -----
rtl/pssf_pkg.sv
rtl/pssf_ram.sv
rtl/pssf_ctrl.sv
rtl/per_source_sequence_filter_core.sv
dv/pssf_checker.sv
dv/tb_top.sv
